/* hw/rtl/first_fit_bitmap_allocator_macros.svh */
// Assertion helpers for the allocator RTL.
`ifndef FIRST_FIT_BITMAP_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_BITMAP_ALLOCATOR_MACROS_SVH

// Same-cycle implication under the active-low reset.
`define FFBA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator assertion failed");

// Next-cycle implication under the active-low reset.
`define FFBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator assertion failed");

`endif

/* hw/rtl/ffba_pkg.sv */
package ffba_pkg;

    localparam int WORD_LG     = 5;
    localparam int WORD_BITS   = 1 << WORD_LG;
    localparam int CHUNK_LG    = 3;
    localparam int CHUNK_BITS  = 1 << CHUNK_LG;
    localparam int NCHUNK_LG   = WORD_LG - CHUNK_LG;
    localparam int QDEPTH      = 2;
    localparam int QLG         = 1;

    typedef logic [2:0] t_status;
    localparam t_status ST_ALLOC     = 3'd0;
    localparam t_status ST_NOSPACE   = 3'd1;
    localparam t_status ST_FREED     = 3'd2;
    localparam t_status ST_NOTALLOC  = 3'd3;
    localparam t_status ST_UNTRACKED = 3'd4;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef enum logic [1:0] {
        CMD_ALLOC,
        CMD_FREE,
        CMD_NOSPACE,
        CMD_NOTALLOC
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [10:0] req_size;
        logic [9:0]  block_start;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_qhead;

endpackage

/* hw/rtl/ffba_req_if.sv */
interface ffba_req_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [10:0] req_size;
    logic [9:0]  block_start;

    modport source(output valid, func, req_size, block_start, input ready);
    modport sink(input valid, func, req_size, block_start, output ready);
endinterface

/* hw/rtl/ffba_rsp_if.sv */
interface ffba_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [9:0]  start_unit;
    logic [10:0] block_size;
    logic [10:0] units_in_use;

    modport source(output valid, status, start_unit, block_size, units_in_use, input ready);
    modport sink(input valid, status, start_unit, block_size, units_in_use, output ready);
endinterface

/* hw/rtl/ffba_front.sv */
module ffba_front #(
    parameter int MEM_UNITS = 1024
) (
    ffba_req_if.sink       i_req,
    input  logic           i_block,
    input  logic           i_q_ready,
    output logic           o_push,
    output ffba_pkg::t_cmd o_cmd
);
    import ffba_pkg::*;

    assign i_req.ready = i_q_ready && !i_block;
    assign o_push      = i_req.valid && i_req.ready;

    always_comb begin
        o_cmd.req_size    = i_req.req_size;
        o_cmd.block_start = i_req.block_start;
        if (i_req.func == FUNC_ALLOC) begin
            if (i_req.req_size == '0 || 32'(i_req.req_size) > 32'(MEM_UNITS)) begin
                o_cmd.kind = CMD_NOSPACE;
            end else begin
                o_cmd.kind = CMD_ALLOC;
            end
        end else begin
            if (32'(i_req.block_start) >= 32'(MEM_UNITS)) begin
                o_cmd.kind = CMD_NOTALLOC;
            end else begin
                o_cmd.kind = CMD_FREE;
            end
        end
    end
endmodule

/* hw/rtl/ffba_queue.sv */
module ffba_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  ffba_pkg::t_cmd   i_cmd,
    input  logic             i_pop,
    output logic             o_ready,
    output ffba_pkg::t_qhead o_head
);
    import ffba_pkg::*;

    t_cmd           r_mem [QDEPTH];
    logic [QLG-1:0] r_wp;
    logic [QLG-1:0] r_rp;
    logic [QLG:0]   r_cnt;
    logic [QLG:0]   n_cnt;

    assign o_ready      = r_cnt != (QLG+1)'(QDEPTH);
    assign o_head.valid = r_cnt != '0;
    assign o_head.cmd   = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end
endmodule

/* hw/rtl/ffba_back.sv */
module ffba_back #(
    parameter int MEM_UNITS = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ffba_pkg::t_qhead i_head,
    output logic             o_pop,
    output logic             o_clearing,
    ffba_rsp_if.source       o_rsp
);
    import ffba_pkg::*;

    localparam int UW     = (MEM_UNITS > 1) ? $clog2(MEM_UNITS) : 1;
    localparam int SW     = $clog2(MEM_UNITS + 1);
    localparam int NWORDS = (MEM_UNITS + WORD_BITS - 1) / WORD_BITS;
    localparam int WAW    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int UXW    = WAW + WORD_LG;

    typedef enum logic [8:0] {
        S_CLEAR    = 9'b000000001,
        S_IDLE     = 9'b000000010,
        S_SCAN_RD  = 9'b000000100,
        S_SCAN     = 9'b000001000,
        S_MARK_RD  = 9'b000010000,
        S_MARK_WR  = 9'b000100000,
        S_FREE_RD  = 9'b001000000,
        S_FREE_CHK = 9'b010000000,
        S_DONE     = 9'b100000000
    } t_state;

    t_state                 r_state, n_state;
    logic [UXW-1:0]         r_cnt, n_cnt;
    logic [WAW-1:0]         r_w, n_w;
    logic [NCHUNK_LG-1:0]   r_c, n_c;
    logic [SW-1:0]          r_run, n_run;
    logic [SW-1:0]          r_size, n_size;
    logic [UXW-1:0]         r_lo, n_lo;
    logic [UXW-1:0]         r_hi, n_hi;
    logic                   r_set, n_set;
    logic [SW-1:0]          r_used, n_used;
    t_status                r_rs_status, n_rs_status;
    logic [9:0]             r_rs_start, n_rs_start;
    logic [SW-1:0]          r_rs_size, n_rs_size;
    logic                   r_ov, n_ov;
    t_status                r_o_status, n_o_status;
    logic [9:0]             r_o_start, n_o_start;
    logic [10:0]            r_o_size, n_o_size;
    logic [10:0]            r_o_used, n_o_used;

    logic [WORD_BITS-1:0]   r_occ_mem [NWORDS];
    logic [SW-1:0]          r_size_mem [MEM_UNITS];
    logic [WORD_BITS-1:0]   r_occ_rd;
    logic [SW-1:0]          r_size_rd;

    logic                   w_occ_we;
    logic [WAW-1:0]         w_occ_wa;
    logic [WORD_BITS-1:0]   w_occ_wd;
    logic [WAW-1:0]         w_occ_ra;
    logic                   w_size_we;
    logic [UW-1:0]          w_size_wa;
    logic [SW-1:0]          w_size_wd;
    logic [UW-1:0]          w_size_ra;

    logic [SW-1:0]          w_run;
    logic                   w_found;
    logic [UXW-1:0]         w_fu;
    logic [WORD_BITS-1:0]   w_mask;

    assign o_clearing       = r_state == S_CLEAR;
    assign o_rsp.valid      = r_ov;
    assign o_rsp.status     = r_o_status;
    assign o_rsp.start_unit = r_o_start;
    assign o_rsp.block_size = r_o_size;
    assign o_rsp.units_in_use = r_o_used;

    // Run search over one eight-bit slice of the current bitmap word.
    always_comb begin
        logic [WORD_LG-1:0] v_bp;
        logic [UXW-1:0]     v_unit;
        logic               v_occ;
        w_run   = r_run;
        w_found = 1'b0;
        w_fu    = '0;
        for (int j = 0; j < CHUNK_BITS; j++) begin
            v_bp   = {r_c, CHUNK_LG'(j)};
            v_unit = {r_w, v_bp};
            v_occ  = r_occ_rd[v_bp] || (32'(v_unit) >= 32'(MEM_UNITS));
            if (!w_found) begin
                if (v_occ) begin
                    w_run = '0;
                end else begin
                    w_run = w_run + 1'b1;
                    if (w_run == r_size) begin
                        w_found = 1'b1;
                        w_fu    = v_unit;
                    end
                end
            end
        end
    end

    always_comb begin
        logic [UXW-1:0] v_u;
        for (int b = 0; b < WORD_BITS; b++) begin
            v_u       = {r_w, WORD_LG'(b)};
            w_mask[b] = (v_u >= r_lo) && (v_u <= r_hi);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_w         = r_w;
        n_c         = r_c;
        n_run       = r_run;
        n_size      = r_size;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_set       = r_set;
        n_used      = r_used;
        n_rs_status = r_rs_status;
        n_rs_start  = r_rs_start;
        n_rs_size   = r_rs_size;
        n_ov        = r_ov && !o_rsp.ready;
        n_o_status  = r_o_status;
        n_o_start   = r_o_start;
        n_o_size    = r_o_size;
        n_o_used    = r_o_used;
        o_pop       = 1'b0;
        w_occ_we    = 1'b0;
        w_occ_wa    = r_w;
        w_occ_wd    = r_set ? (r_occ_rd | w_mask) : (r_occ_rd & ~w_mask);
        w_occ_ra    = r_w;
        w_size_we   = 1'b0;
        w_size_wa   = r_lo[UW-1:0];
        w_size_wd   = r_set ? r_size : '0;
        w_size_ra   = r_lo[UW-1:0];
        case (r_state)
            S_CLEAR: begin
                w_occ_we  = 1'b1;
                w_occ_wa  = r_cnt[UXW-1:WORD_LG];
                w_occ_wd  = '0;
                w_size_we = 1'b1;
                w_size_wa = r_cnt[UW-1:0];
                w_size_wd = '0;
                if (r_cnt == UXW'(MEM_UNITS - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_head.valid) begin
                    o_pop       = 1'b1;
                    n_rs_status = ST_NOTALLOC;
                    n_rs_start  = '0;
                    n_rs_size   = '0;
                    case (i_head.cmd.kind)
                        CMD_ALLOC: begin
                            n_size  = SW'(i_head.cmd.req_size);
                            n_run   = '0;
                            n_w     = '0;
                            n_c     = '0;
                            n_state = S_SCAN_RD;
                        end
                        CMD_FREE: begin
                            n_lo    = UXW'(i_head.cmd.block_start);
                            n_state = S_FREE_RD;
                        end
                        CMD_NOSPACE: begin
                            n_rs_status = ST_NOSPACE;
                            n_state     = S_DONE;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN_RD: begin
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (w_found) begin
                    n_lo    = w_fu - UXW'(r_size) + 1'b1;
                    n_hi    = w_fu;
                    n_set   = 1'b1;
                    n_w     = n_lo[UXW-1:WORD_LG];
                    n_state = S_MARK_RD;
                end else begin
                    n_run = w_run;
                    if (r_c == '1) begin
                        if (r_w == WAW'(NWORDS - 1)) begin
                            n_rs_status = ST_NOSPACE;
                            n_rs_start  = '0;
                            n_rs_size   = '0;
                            n_state     = S_DONE;
                        end else begin
                            n_w     = r_w + 1'b1;
                            n_c     = '0;
                            n_state = S_SCAN_RD;
                        end
                    end else begin
                        n_c = r_c + 1'b1;
                    end
                end
            end
            S_MARK_RD: begin
                n_state = S_MARK_WR;
            end
            S_MARK_WR: begin
                w_occ_we = 1'b1;
                if (r_w == r_hi[UXW-1:WORD_LG]) begin
                    w_size_we   = 1'b1;
                    n_used      = r_set ? (r_used + r_size) : (r_used - r_size);
                    n_rs_status = r_set ? ST_ALLOC : ST_FREED;
                    n_rs_start  = 10'(r_lo);
                    n_rs_size   = r_size;
                    n_state     = S_DONE;
                end else begin
                    n_w     = r_w + 1'b1;
                    n_state = S_MARK_RD;
                end
            end
            S_FREE_RD: begin
                w_occ_ra = r_lo[UXW-1:WORD_LG];
                n_state  = S_FREE_CHK;
            end
            S_FREE_CHK: begin
                if (!r_occ_rd[r_lo[WORD_LG-1:0]]) begin
                    n_rs_status = ST_NOTALLOC;
                    n_state     = S_DONE;
                end else if (r_size_rd == '0) begin
                    n_rs_status = ST_UNTRACKED;
                    n_state     = S_DONE;
                end else begin
                    n_size  = r_size_rd;
                    n_hi    = r_lo + UXW'(r_size_rd) - 1'b1;
                    n_set   = 1'b0;
                    n_w     = r_lo[UXW-1:WORD_LG];
                    n_state = S_MARK_RD;
                end
            end
            S_DONE: begin
                if (!r_ov || o_rsp.ready) begin
                    n_ov       = 1'b1;
                    n_o_status = r_rs_status;
                    n_o_start  = r_rs_start;
                    n_o_size   = 11'(r_rs_size);
                    n_o_used   = 11'(r_used);
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt   <= '0;
            r_used  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_used  <= n_used;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w         <= n_w;
        r_c         <= n_c;
        r_run       <= n_run;
        r_size      <= n_size;
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_set       <= n_set;
        r_rs_status <= n_rs_status;
        r_rs_start  <= n_rs_start;
        r_rs_size   <= n_rs_size;
        r_o_status  <= n_o_status;
        r_o_start   <= n_o_start;
        r_o_size    <= n_o_size;
        r_o_used    <= n_o_used;
    end

    always_ff @(posedge i_clk) begin
        if (w_occ_we) begin
            r_occ_mem[w_occ_wa] <= w_occ_wd;
        end
        r_occ_rd <= r_occ_mem[w_occ_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_size_we) begin
            r_size_mem[w_size_wa] <= w_size_wd;
        end
        r_size_rd <= r_size_mem[w_size_ra];
    end
endmodule

/* hw/rtl/first_fit_bitmap_allocator.sv */
// Allocate: the request is taken, the bitmap is scanned word by word (32 units a word),
// then the found run's words are marked and the result presented; a full scan with no run
// gives no space. Free: the block is checked, its bitmap words are cleared and the result
// presented; a request can be rejected on range or by the checks. One request is worked
// at a time, and a result waiting for its transfer holds the back end. After reset the
// bitmap and size memories are swept over MEM_UNITS units, with no request transfer taken.
`include "first_fit_bitmap_allocator_macros.svh"
module first_fit_bitmap_allocator #(
    parameter int MEM_UNITS = 1024
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ffba_req_if.sink   i_req,
    ffba_rsp_if.source o_rsp
);
    import ffba_pkg::*;

    t_cmd   w_cmd;
    t_qhead w_head;
    logic   w_push;
    logic   w_pop;
    logic   w_q_ready;
    logic   w_clearing;

    ffba_front #(.MEM_UNITS(MEM_UNITS)) u_front (
        .i_req     (i_req),
        .i_block   (w_clearing),
        .i_q_ready (w_q_ready),
        .o_push    (w_push),
        .o_cmd     (w_cmd)
    );

    ffba_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .i_pop   (w_pop),
        .o_ready (w_q_ready),
        .o_head  (w_head)
    );

    ffba_back #(.MEM_UNITS(MEM_UNITS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (w_head),
        .o_pop      (w_pop),
        .o_clearing (w_clearing),
        .o_rsp      (o_rsp)
    );

    `FFBA_ASSERT_IMP(a_no_take_while_clearing, i_clk, i_rst_n, w_clearing, !i_req.ready)
    `FFBA_ASSERT_NEXT(a_no_result_while_clearing, i_clk, i_rst_n, w_clearing, !o_rsp.valid)
    `FFBA_ASSERT_IMP(a_failure_zero, i_clk, i_rst_n, (o_rsp.valid && o_rsp.status != ST_ALLOC && o_rsp.status != ST_FREED), (o_rsp.start_unit == '0 && o_rsp.block_size == '0))
    `FFBA_ASSERT_IMP(a_use_bounded, i_clk, i_rst_n, o_rsp.valid, (32'(o_rsp.units_in_use) <= 32'(MEM_UNITS)))
endmodule
